@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands. The including scope provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lzss_pkg.sv @@
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared constants, codes and controller/datapath bundles of the LZSS core.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_AW      = $clog2(WINDOW_SIZE);
  localparam logic [15:0] MAX_OUTPUT = 16'hFFFF;
  // Match length field is stored biased by two
  localparam int CNT_BIAS    = 2;
  localparam int CNT_W       = 5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_DONE  = 2'd1,
    ST_TRUNC = 2'd2
  } lzss_status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         acc;         // input request taken: latch in_last
    logic         set_tgt_lo;  // first header byte
    logic         set_tgt_hi;  // second header byte
    logic         load_flags;  // new flag byte
    logic         adv_flag;    // consume one flag bit
    logic         hold_low;    // low byte of a match word
    logic         lit_latch;   // literal byte
    logic         load_copy;   // high byte of a match word
    logic         rd_issue;    // history read for the next copy byte
    logic         emit_data;   // push a data result
    logic         src_copy;    // data comes from history, else literal
    logic         emit_stat;   // push a status-only result
    lzss_status_t stat_code;
  } lzss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic flag_needed;
    logic flag_bit;
    logic target_zero;
    logic out_free;
    logic hit;         // next data byte reaches the target size
    logic copy_final;  // next copy byte is the last of its match
    logic last_q;      // latched in_last of the byte in flight
  } lzss_sts_t;

endpackage

@@ rtl/core/lzss_in_if.sv @@
// ----------------------------------------------------------------------------
// lzss_in_if
// Compressed byte channel: valid/ready handshake with byte and end marker.
// ----------------------------------------------------------------------------
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/core/lzss_out_if.sv @@
// ----------------------------------------------------------------------------
// lzss_out_if
// Decompressed result channel: valid/ready handshake with byte and status.
// ----------------------------------------------------------------------------
interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [1:0] out_status;
  logic       out_run_end;

  modport source (output valid, output out_byte, output out_valid,
                  output out_status, output out_run_end, input ready);
  modport sink   (input valid, input out_byte, input out_valid,
                  input out_status, input out_run_end, output ready);
endinterface

@@ rtl/core/lzss_ram.sv @@
// ----------------------------------------------------------------------------
// lzss_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/lzss_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzss_ctrl
// Parse and copy sequencer: walks the header, flag bits, literals and
// matches, and paces data and status results into the output register.
// ----------------------------------------------------------------------------
module lzss_ctrl
  import lzss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  lzss_sts_t sts,
  output lzss_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_HDR0, S_HDR1, S_HDR2, S_HDR3,
    S_BODY, S_REFHI, S_LIT, S_CRD, S_CWR, S_STAT, S_HALT
  } state_t;

  state_t       state, state_next;
  lzss_status_t stat_code, stat_code_next;
  logic         accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_HDR0;
      stat_code <= ST_DATA;
    end else begin
      state     <= state_next;
      stat_code <= stat_code_next;
    end
  end

  // Input is taken only in parse states; a halted core drains and drops bytes
  always_comb begin
    unique case (state)
      S_HDR0, S_HDR1, S_HDR2, S_HDR3,
      S_BODY, S_REFHI, S_HALT: in_ready = 1'b1;
      default:                 in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    stat_code_next = stat_code;
    cmd            = '0;
    cmd.stat_code  = stat_code;
    cmd.acc        = accept && (state != S_HALT);

    unique case (state)
      S_HDR0, S_HDR1, S_HDR2: begin
        if (accept) begin
          cmd.set_tgt_lo = (state == S_HDR0);
          cmd.set_tgt_hi = (state == S_HDR1);
          if (in_last) begin
            state_next     = S_STAT;
            stat_code_next = ST_TRUNC;
          end else begin
            unique case (state)
              S_HDR0:  state_next = S_HDR1;
              S_HDR1:  state_next = S_HDR2;
              default: state_next = S_HDR3;
            endcase
          end
        end
      end

      // Empty output finishes right after the header
      S_HDR3: begin
        if (accept) begin
          if (sts.target_zero) begin
            state_next     = S_STAT;
            stat_code_next = ST_DONE;
          end else if (in_last) begin
            state_next     = S_STAT;
            stat_code_next = ST_TRUNC;
          end else begin
            state_next = S_BODY;
          end
        end
      end

      S_BODY: begin
        if (accept) begin
          if (sts.flag_needed) begin
            cmd.load_flags = 1'b1;
            if (in_last) begin
              state_next     = S_STAT;
              stat_code_next = ST_TRUNC;
            end
          end else if (sts.flag_bit) begin
            cmd.lit_latch = 1'b1;
            cmd.adv_flag  = 1'b1;
            state_next    = S_LIT;
          end else begin
            cmd.hold_low = 1'b1;
            if (in_last) begin
              state_next     = S_STAT;
              stat_code_next = ST_TRUNC;
            end else begin
              state_next = S_REFHI;
            end
          end
        end
      end

      S_REFHI: begin
        if (accept) begin
          cmd.load_copy = 1'b1;
          cmd.adv_flag  = 1'b1;
          state_next    = S_CRD;
        end
      end

      S_LIT: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          state_next    = (sts.hit || sts.last_q) ? S_HALT : S_BODY;
        end
      end

      S_CRD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_CWR;
      end

      // One history byte per read; the match ends early at the target size
      S_CWR: begin
        if (sts.out_free) begin
          cmd.emit_data = 1'b1;
          cmd.src_copy  = 1'b1;
          if (sts.hit || sts.copy_final) begin
            state_next = (sts.hit || sts.last_q) ? S_HALT : S_BODY;
          end else begin
            state_next = S_CRD;
          end
        end
      end

      S_STAT: begin
        if (sts.out_free) begin
          cmd.emit_stat = 1'b1;
          state_next    = S_HALT;
        end
      end

      S_HALT: state_next = S_HALT;

      default: state_next = S_HALT;
    endcase
  end

endmodule

@@ rtl/core/lzss_dp.sv @@
// ----------------------------------------------------------------------------
// lzss_dp
// Datapath: header and flag registers, match length/offset, history window
// with fill tracking, and the output register.
// ----------------------------------------------------------------------------
module lzss_dp
  import lzss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  lzss_cmd_t  cmd,
  output lzss_sts_t  sts,
  input  logic       out_ready,
  output logic       out_full,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic       out_run_end
);

  logic [15:0]       target_size;
  logic [15:0]       produced_count;
  logic [WIN_AW-1:0] write_position;
  logic              wrapped;
  logic [7:0]        flag_bits;
  logic [3:0]        flag_idx;
  logic [7:0]        held_low_byte;
  logic [7:0]        lit_byte;
  logic [CNT_W-1:0]  copy_cnt;
  logic [WIN_AW-1:0] copy_off;
  logic              src_ok;
  logic              last_q;

  logic [WIN_AW-1:0] src_addr;
  logic [7:0]        ram_q;
  logic [7:0]        data_byte;
  logic [15:0]       produced_inc;
  logic              hit;
  logic              final_res;
  logic [15:0]       hdr_size;
  lzss_status_t      data_status;

  assign produced_inc = produced_count + 16'd1;
  assign hit          = (produced_inc == target_size);
  assign src_addr     = write_position - copy_off;
  assign hdr_size     = {in_byte, target_size[7:0]};

  // Slots not yet written since reset read as zero
  assign data_byte = cmd.src_copy ? (src_ok ? ram_q : 8'd0) : lit_byte;
  assign final_res = !cmd.src_copy || hit || (copy_cnt == CNT_W'(1));

  always_comb begin
    if (hit) begin
      data_status = ST_DONE;
    end else if (final_res && last_q) begin
      data_status = ST_TRUNC;
    end else begin
      data_status = ST_DATA;
    end
  end

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.emit_data),
    .waddr (write_position),
    .wdata (data_byte),
    .re    (cmd.rd_issue),
    .raddr (src_addr),
    .rdata (ram_q)
  );

  // Parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_size   <= '0;
      flag_bits     <= '0;
      flag_idx      <= 4'd8;
      held_low_byte <= '0;
      last_q        <= 1'b0;
    end else begin
      if (cmd.acc) begin
        last_q <= in_last;
      end
      if (cmd.set_tgt_lo) begin
        target_size <= {8'd0, in_byte};
      end
      if (cmd.set_tgt_hi) begin
        target_size <= (hdr_size > MAX_OUTPUT) ? MAX_OUTPUT : hdr_size;
      end
      if (cmd.load_flags) begin
        flag_bits <= in_byte;
        flag_idx  <= 4'd0;
      end else if (cmd.adv_flag) begin
        flag_idx <= flag_idx + 4'd1;
      end
      if (cmd.hold_low) begin
        held_low_byte <= in_byte;
      end
    end
  end

  // Literal and match registers
  always_ff @(posedge clk) begin
    if (cmd.lit_latch) begin
      lit_byte <= in_byte;
    end
    if (cmd.load_copy) begin
      copy_cnt <= CNT_W'(in_byte[7:4]) + CNT_W'(CNT_BIAS);
      copy_off <= {in_byte[3:0], held_low_byte};
    end else if (cmd.emit_data && cmd.src_copy) begin
      copy_cnt <= copy_cnt - CNT_W'(1);
    end
    if (cmd.rd_issue) begin
      src_ok <= wrapped || (src_addr < write_position);
    end
  end

  // Window position and output count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      wrapped        <= 1'b0;
      produced_count <= '0;
    end else if (cmd.emit_data) begin
      write_position <= write_position + WIN_AW'(1);
      produced_count <= produced_inc;
      if (write_position == {WIN_AW{1'b1}}) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.emit_data || cmd.emit_stat) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      out_byte    <= data_byte;
      out_valid   <= 1'b1;
      out_status  <= data_status;
      out_run_end <= final_res;
    end else if (cmd.emit_stat) begin
      out_byte    <= 8'd0;
      out_valid   <= 1'b0;
      out_status  <= cmd.stat_code;
      out_run_end <= 1'b1;
    end
  end

  assign sts.flag_needed = flag_idx[3];
  assign sts.flag_bit    = flag_bits[flag_idx[2:0]];
  assign sts.target_zero = (target_size == 16'd0);
  assign sts.out_free    = !out_full || out_ready;
  assign sts.hit         = hit;
  assign sts.copy_final  = (copy_cnt == CNT_W'(1));
  assign sts.last_q      = last_q;

endmodule

@@ rtl/core/lzss_stream_decompressor_core.sv @@
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_core
// LZSS decoder with a 4 KiB history, one compressed byte per request in,
// one decoded byte or status per request out.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream carries the compressed stream one byte per request, header
//   included; in_last marks its final byte. out_stream carries decoded bytes
//   and status-only results; out_run_end flags the last result of each
//   input byte, out_status reports target reached or early end.
// Timing:
//   Header, flag and match-low bytes are registered without a data result. A literal is
//   latched on acceptance, then written to history and emitted in S_LIT.
//   A match is accepted with its high byte, then copies up to 17 bytes,
//   each a history read (S_CRD) then a write and emit (S_CWR); no input
//   is taken meanwhile. The single-port-read history RAM sets this pace.
// Reset:
//   Synchronous rst returns to the first header byte. The history needs no
//   clearing pass: a fill mark makes never-written slots read as zero.
// Stall:
//   Results sit in an output register; while out_stream is not ready the
//   core holds its work and stops accepting input once it needs that slot.
//   After completion or early end, further input bytes are taken and dropped.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_core
  import lzss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lzss_in_if.sink     in_stream,
  lzss_out_if.source  out_stream
);

`include "assert_macros.svh"

  lzss_cmd_t cmd;
  lzss_sts_t sts;
  logic      in_ready;
  logic      out_full;

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .in_last  (in_stream.in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzss_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_stream.in_byte),
    .in_last     (in_stream.in_last),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_stream.ready),
    .out_full    (out_full),
    .out_byte    (out_stream.out_byte),
    .out_valid   (out_stream.out_valid),
    .out_status  (out_stream.out_status),
    .out_run_end (out_stream.out_run_end)
  );

  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_full;

  // Results are pushed only into a free output slot
  `ASSERT_IMPL(a_emit_free, cmd.emit_data || cmd.emit_stat, sts.out_free, "emit into busy output")
  // No result is produced in a cycle that takes input
  `ASSERT_IMPL(a_emit_no_accept, in_ready, !(cmd.emit_data || cmd.emit_stat), "emit while taking input")
  // A status-only result always closes its run with a non-data status
  `ASSERT_IMPL(a_stat_only, out_stream.valid && !out_stream.out_valid, out_stream.out_run_end && (out_stream.out_status != ST_DATA), "bad status-only result")
  // Each history read is consumed before the next one
  `ASSERT_NEXT(a_rd_spacing, cmd.rd_issue, !cmd.rd_issue, "back-to-back history reads")

endmodule

@@ tb/lzss_stream_decompressor_core_tb.sv @@
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_core_tb
// Self-checking bench for the LZSS stream decoder. One compressed stream is
// built per run (header, directed literal/match groups, then random groups),
// and the seed picks how it ends: zero target, cut in the header, cut in the
// body, or target reached. A behavioral decoder predicts every result at
// input acceptance; the monitor compares each result against the oldest one.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_core_tb
  import lzss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_BODY, PH_REFHI, PH_HALT
  } parse_phase_t;

  typedef enum int {
    SC_ZERO_TARGET, SC_HEADER_CUT, SC_BODY_CUT, SC_TARGET_HIT
  } ending_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_item_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         data_valid;
    lzss_status_t status;
    logic         run_end;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzss_in_if  in_if();
  lzss_out_if out_if();

  lzss_stream_decompressor_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  stream_item_t stream_q[$];
  int           yield_q[$];     // data bytes each item would produce
  decoded_t     decoded_q[$];   // results still owed by the decoder
  decoded_t     step_q[$];      // results of the byte being decoded
  int           total_items;
  int           accepted;
  int           fail_count;

  // Decoder state
  logic [7:0]   hist [WINDOW_SIZE];
  logic [11:0]  wpos;
  logic [15:0]  produced;
  logic [15:0]  target;
  logic [7:0]   flags;
  logic [3:0]   flag_idx;
  logic [7:0]   held_lo;
  parse_phase_t phase;

  // Idle percentage by stage: sender light/receiver heavy, swapped, none
  function automatic int idle_pct(input bit sender);
    int stage;
    stage = (total_items == 0) ? 0 : accepted * 3 / total_items;
    if (stage == 0) return sender ? 6 : 79;
    if (stage == 1) return sender ? 79 : 6;
    return 0;
  endfunction

  task automatic emit_data(input logic [7:0] b);
    hist[wpos] = b;
    wpos++;
    produced++;
    if (produced == target) begin
      step_q.push_back('{data: b, data_valid: 1'b1, status: ST_DONE, run_end: 1'b0});
      phase = PH_HALT;
    end else begin
      step_q.push_back('{data: b, data_valid: 1'b1, status: ST_DATA, run_end: 1'b0});
    end
  endtask

  // Decode one accepted byte and queue the results it owes
  task automatic decode_step(input logic [7:0] b, input logic last);
    logic [15:0] word;
    logic [11:0] src;
    int          count;
    step_q.delete();
    case (phase)
      PH_HDR0: begin
        target = {8'h00, b};
        phase  = PH_HDR1;
      end
      PH_HDR1: begin
        // 16-bit size never exceeds the output limit
        target[15:8] = b;
        phase        = PH_HDR2;
      end
      PH_HDR2: phase = PH_HDR3;
      PH_HDR3: begin
        phase = PH_BODY;
        if (produced >= target) begin
          step_q.push_back('{data: 8'h00, data_valid: 1'b0, status: ST_DONE, run_end: 1'b0});
          phase = PH_HALT;
        end
      end
      PH_BODY: begin
        if (flag_idx >= 4'd8) begin
          flags    = b;
          flag_idx = 4'd0;
        end else if (flags[flag_idx[2:0]]) begin
          flag_idx++;
          emit_data(b);
        end else begin
          held_lo = b;
          phase   = PH_REFHI;
        end
      end
      PH_REFHI: begin
        word  = {b, held_lo};
        count = int'(word[15:12]) + CNT_BIAS;
        phase = PH_BODY;
        flag_idx++;
        // Copy may overlap bytes it writes itself
        for (int k = 0; k < count && phase != PH_HALT; k++) begin
          src = wpos - word[11:0];
          emit_data(hist[src]);
        end
      end
      default: return;
    endcase

    if (phase != PH_HALT && last) begin
      phase = PH_HALT;
      if (step_q.size() > 0)
        step_q[step_q.size() - 1].status = ST_TRUNC;
      else
        step_q.push_back('{data: 8'h00, data_valid: 1'b0, status: ST_TRUNC, run_end: 1'b0});
    end
    if (step_q.size() > 0)
      step_q[step_q.size() - 1].run_end = 1'b1;
    foreach (step_q[i])
      decoded_q.push_back(step_q[i]);
  endtask

  task automatic push_byte(input logic [7:0] b, input int yield_n);
    stream_q.push_back('{data: b, last: 1'b0});
    yield_q.push_back(yield_n);
  endtask

  task automatic push_match(input logic [7:0] lo, input logic [7:0] hi);
    push_byte(lo, 0);
    push_byte(hi, int'(hi[7:4]) + CNT_BIAS);
  endtask

  // Build the whole stream and pick how it ends
  task automatic build_stream();
    logic [7:0] fl;
    ending_t    ending;
    int         sel;
    int         k;
    int         body_end;
    int         prior;
    int         tgt;
    for (int i = 0; i < 4; i++)
      push_byte(8'h00, 0);

    // Directed: literal extremes
    push_byte(8'hFF, 0);
    push_byte(8'h00, 1);
    push_byte(8'hFF, 1);
    push_byte(8'h5A, 1);
    push_byte(8'hA5, 1);
    push_byte(8'h01, 1);
    push_byte(8'h80, 1);
    push_byte(8'h7F, 1);
    push_byte(8'hFE, 1);
    // Directed: four matches then four literals
    push_byte(8'hF0, 0);
    push_match(8'h00, 8'h00);   // offset zero, shortest copy
    push_match(8'hFF, 8'hFF);   // offset before the start, longest copy
    push_match(8'h01, 8'hF0);   // self-overlapping run
    push_match(8'h08, 8'h30);
    for (int i = 0; i < 4; i++)
      push_byte(8'($urandom), 1);

    // Random flag groups with random content
    while (stream_q.size() < 226) begin
      fl = 8'($urandom);
      push_byte(fl, 0);
      for (int i = 0; i < 8; i++) begin
        if (fl[i])
          push_byte(8'($urandom), 1);
        else
          push_match(8'($urandom), 8'($urandom));
      end
    end
    body_end = stream_q.size() - 1;
    stream_q[body_end].last = 1'b1;

    sel = $urandom_range(0, 9);
    if (sel == 0)
      ending = SC_ZERO_TARGET;
    else if (sel == 1)
      ending = SC_HEADER_CUT;
    else if (sel < 6)
      ending = SC_BODY_CUT;
    else
      ending = SC_TARGET_HIT;

    case (ending)
      SC_ZERO_TARGET: tgt = 0;
      SC_HEADER_CUT: begin
        tgt = $urandom_range(1, 65535);
        stream_q[$urandom_range(0, 3)].last = 1'b1;
      end
      SC_BODY_CUT: begin
        k     = $urandom_range(body_end - 30, body_end);
        prior = 0;
        for (int i = 0; i <= k; i++)
          prior += yield_q[i];
        tgt = $urandom_range(prior + 1, 65535);
        stream_q[k].last = 1'b1;
      end
      default: begin
        // End on a data-producing item, often inside a copy
        do
          k = $urandom_range(body_end - 30, body_end);
        while (yield_q[k] == 0);
        prior = 0;
        for (int i = 0; i < k; i++)
          prior += yield_q[i];
        tgt = prior + $urandom_range(1, yield_q[k]);
      end
    endcase
    stream_q[0].data = tgt[7:0];
    stream_q[1].data = tgt[15:8];
    stream_q[2].data = 8'($urandom);
    stream_q[3].data = 8'($urandom);
    total_items = stream_q.size();
  endtask

  // Driver: one request per accepted compressed byte
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= 8'h00;
      in_if.in_last <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_step(in_if.in_byte, in_if.in_last);
        accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (stream_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= stream_q[0].data;
          in_if.in_last <= stream_q[0].last;
          void'(stream_q.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result request with the oldest expectation
  always @(posedge clk) begin
    decoded_t exp_r;
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %0h out_valid %0b out_status %0d",
                 out_if.out_byte, out_if.out_valid, out_if.out_status);
          fail_count++;
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_if.out_byte !== exp_r.data) begin
            $error("out_byte: expected %0h, actual %0h", exp_r.data, out_if.out_byte);
            fail_count++;
          end
          if (out_if.out_valid !== exp_r.data_valid) begin
            $error("out_valid: expected %0b, actual %0b", exp_r.data_valid,
                   out_if.out_valid);
            fail_count++;
          end
          if (out_if.out_status !== exp_r.status) begin
            $error("out_status: expected %0d, actual %0d", exp_r.status,
                   out_if.out_status);
            fail_count++;
          end
          if (out_if.out_run_end !== exp_r.run_end) begin
            $error("out_run_end: expected %0b, actual %0b", exp_r.run_end,
                   out_if.out_run_end);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Main sequence
  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    accepted      = 0;
    fail_count    = 0;
    total_items   = 0;
    foreach (hist[i])
      hist[i] = 8'h00;
    wpos     = '0;
    produced = '0;
    target   = '0;
    flags    = '0;
    flag_idx = 4'd8;
    held_lo  = '0;
    phase    = PH_HDR0;
    build_stream();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (stream_q.size() > 0 || in_if.valid) @(posedge clk);
    while (decoded_q.size() > 0) @(posedge clk);
    // Longest match still in flight, plus margin
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
